// ----- rtl/core/ssht_pkg.sv -----
// Shared types, sizes and helpers for the space-saving frequent-key table.
// Used by the cell, the controller and the top level; depends on nothing.
package ssht_pkg;

   localparam int SLOTS      = 64;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 32;
   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILL_BITS  = $clog2(SLOTS + 1);
   localparam int CAP_BITS   = 7;
   localparam int CMP_BITS   = (CAP_BITS > FILL_BITS) ? CAP_BITS : FILL_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CAP_BITS-1:0] ACTIVE_SLOTS_RESET = CAP_BITS'(64);

   // Register index, taken from paddr bit 2.
   localparam logic CSR_ACTIVE_SLOTS = 1'b0;

   typedef enum logic [0:0] {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Search word that walks down the chain, one cell per cycle.
   typedef struct packed {
      logic                  live;
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic                  can_fill;
      logic                  hit;
      logic                  claimed;
      logic [COUNT_BITS-1:0] count;
      logic                  min_found;
      logic [COUNT_BITS-1:0] min_count;
      logic [IDX_BITS-1:0]   min_idx;
      logic [KEY_BITS-1:0]   min_key;
   } wave_type;

   // Replacement of the minimum entry, broadcast to every cell.
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] idx;
      logic [KEY_BITS-1:0] key;
   } commit_type;

   function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + COUNT_BITS'(1);
   endfunction

endpackage

// ----- rtl/core/space_saving_heavy_hitter_table_unit.sv -----
// Space-saving frequent-key table: a row of SLOTS cells walked by one search word.
// A request word passes the head register, every cell register, the finish register
// and the result register; a new word is taken only once the last one is finished.
// Reset (synchronous) clears the valid flags of slots, search words and result and
// the fill count and sets active_slots to 64; keys, counts and result data stay.
// Depends on ssht_pkg, ssht_cell and ssht_ctrl.
module space_saving_heavy_hitter_table_unit import ssht_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [KEY_BITS-1:0]      req_key,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COUNT_BITS-1:0]    rsp_estimate,
   output logic                     rsp_was_tracked,
   output logic                     rsp_evicted,
   output logic [KEY_BITS-1:0]      rsp_evicted_key,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // The controller takes one request word at a time and launches it as a search
   // word into cell 0. Each cycle the word moves one cell down the row. A cell
   // whose key matches increments its own count (for an update) and marks the
   // word as a hit. Valid slots always form a prefix of the row, so the first
   // empty cell the word meets has seen every tracked key already; if the table
   // was below capacity at launch, that cell claims an update's key at count one.
   // Along the way the word also keeps the lowest-index minimum count among the
   // valid cells. When the word leaves the last cell, the controller finishes
   // the item: for an update that neither hit nor claimed a slot it broadcasts a
   // replacement to the minimum cell, which takes the new key and min plus one.
   // The result then goes into an output register, so the next request can be
   // accepted while the previous result still waits on rsp_ready.

   wave_type   chain [SLOTS+1];
   commit_type commit;

   ssht_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .rsp_was_tracked (rsp_was_tracked),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .head            (chain[0]),
      .tail            (chain[SLOTS]),
      .commit          (commit)
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ssht_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(i)),
         .wave_in  (chain[i]),
         .commit   (commit),
         .wave_out (chain[i+1])
      );
   end

   // A launched search word passes every cell register and reaches the end of the row.
   a_walk_length: assert property (@(posedge clock) disable iff (reset)
      chain[0].live |-> ##SLOTS chain[SLOTS].live)
      else $error("search word did not arrive at the end of the row on time");

   // A replacement broadcast always comes with an eviction result.
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      commit.en |=> (rsp_valid && rsp_evicted))
      else $error("replacement without an eviction result");

   // A key that was already tracked is never reported as an eviction.
   a_evict_untracked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_evicted && rsp_was_tracked))
      else $error("eviction reported for a tracked key");

endmodule

// ----- rtl/core/ssht_cell.sv -----
// One table slot: key, count and valid flag, plus the search word register.
// Depends on ssht_pkg.
module ssht_cell import ssht_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  wave_type            wave_in,
   input  commit_type          commit,
   output wave_type            wave_out
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   wave_type              wave_ff, wave_in_next;
   logic                  hit_here, claim_here, min_here, commit_here;

   always_comb begin
      hit_here    = wave_in.live && valid_ff && (key_ff == wave_in.key);
      claim_here  = wave_in.live && !valid_ff && (wave_in.op == OP_UPDATE) &&
                    wave_in.can_fill && !wave_in.claimed && !wave_in.hit;
      min_here    = wave_in.live && valid_ff &&
                    (!wave_in.min_found || (count_ff < wave_in.min_count));
      commit_here = commit.en && (commit.idx == cell_idx);

      valid_in     = valid_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      wave_in_next = wave_in;

      if (hit_here) begin
         wave_in_next.hit = 1'b1;
         if (wave_in.op == OP_UPDATE) begin
            count_in           = count_inc(count_ff);
            wave_in_next.count = count_inc(count_ff);
         end else begin
            wave_in_next.count = count_ff;
         end
      end

      if (claim_here) begin
         valid_in             = 1'b1;
         key_in               = wave_in.key;
         count_in             = COUNT_BITS'(1);
         wave_in_next.claimed = 1'b1;
         wave_in_next.count   = COUNT_BITS'(1);
      end

      if (min_here) begin
         wave_in_next.min_found = 1'b1;
         wave_in_next.min_count = count_ff;
         wave_in_next.min_idx   = cell_idx;
         wave_in_next.min_key   = key_ff;
      end

      if (commit_here) begin
         key_in   = commit.key;
         count_in = count_inc(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         wave_ff.live <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign wave_out = wave_ff;

endmodule

// ----- rtl/core/ssht_ctrl.sv -----
// Sequencer for the table: launches a search word, finishes each request word,
// holds the fill count, the result register and the configuration register.
// Depends on ssht_pkg.
module ssht_ctrl import ssht_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [KEY_BITS-1:0]      req_key,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COUNT_BITS-1:0]    rsp_estimate,
   output logic                     rsp_was_tracked,
   output logic                     rsp_evicted,
   output logic [KEY_BITS-1:0]      rsp_evicted_key,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output wave_type                 head,
   input  wave_type                 tail,
   output commit_type               commit
);

   state_type             state_ff, state_in;
   wave_type              head_ff, head_in;
   wave_type              fin_ff, fin_in;
   logic [FILL_BITS-1:0]  filled_ff, filled_in;
   logic [CAP_BITS-1:0]   active_slots_ff, active_slots_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_estimate_ff, rsp_estimate_in;
   logic                  rsp_was_tracked_ff, rsp_was_tracked_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]   rsp_evicted_key_ff, rsp_evicted_key_in;

   logic [CMP_BITS-1:0]   cap;
   logic                  can_fill;
   logic                  evict;
   logic                  csr_write;

   // Capacity clamped to the range one to SLOTS.
   always_comb begin
      if (active_slots_ff == '0) begin
         cap = CMP_BITS'(1);
      end else if (CMP_BITS'(active_slots_ff) > CMP_BITS'(SLOTS)) begin
         cap = CMP_BITS'(SLOTS);
      end else begin
         cap = CMP_BITS'(active_slots_ff);
      end
      can_fill = CMP_BITS'(filled_ff) < cap;
   end

   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      head_in.live       = 1'b0;
      fin_in             = fin_ff;
      filled_in          = filled_ff;
      commit             = '0;
      req_ready          = 1'b0;
      evict              = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_estimate_in    = rsp_estimate_ff;
      rsp_was_tracked_in = rsp_was_tracked_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               head_in          = '0;
               head_in.live     = 1'b1;
               head_in.op       = op_type'(req_op);
               head_in.key      = req_key;
               head_in.can_fill = can_fill;
               state_in         = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tail.live) begin
               fin_in   = tail;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               evict = (fin_ff.op == OP_UPDATE) && !fin_ff.hit && !fin_ff.claimed &&
                       fin_ff.min_found;
               commit.en  = evict;
               commit.idx = fin_ff.min_idx;
               commit.key = fin_ff.key;
               if (fin_ff.claimed) begin
                  filled_in = filled_ff + FILL_BITS'(1);
               end
               rsp_valid_in       = 1'b1;
               rsp_was_tracked_in = fin_ff.hit;
               rsp_evicted_in     = evict;
               rsp_evicted_key_in = evict ? fin_ff.min_key : '0;
               if (evict) begin
                  rsp_estimate_in = count_inc(fin_ff.min_count);
               end else if (fin_ff.hit || fin_ff.claimed) begin
                  rsp_estimate_in = fin_ff.count;
               end else begin
                  rsp_estimate_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff.live <= 1'b0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff             <= fin_in;
      rsp_estimate_ff    <= rsp_estimate_in;
      rsp_was_tracked_ff <= rsp_was_tracked_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   // Configuration register.
   always_comb begin
      csr_write       = csr_psel && csr_penable && csr_pwrite &&
                        (csr_paddr[2] == CSR_ACTIVE_SLOTS);
      active_slots_in = csr_write ? csr_pwdata[CAP_BITS-1:0] : active_slots_ff;
      if (csr_paddr[2] == CSR_ACTIVE_SLOTS) begin
         csr_prdata = CSR_DATA_BITS'(active_slots_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= ACTIVE_SLOTS_RESET;
      end else begin
         active_slots_ff <= active_slots_in;
      end
   end

   assign csr_pready      = 1'b1;
   assign head            = head_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_estimate    = rsp_estimate_ff;
   assign rsp_was_tracked = rsp_was_tracked_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ----- verif/ssht_result_checker.sv -----
// Result checker for the space-saving frequent-key table: keeps a mirror of the table,
// predicts the response word of every accepted request word and compares field by field.
// Depends on ssht_pkg for sizes, the op encoding and the capacity register index.
module ssht_result_checker import ssht_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_op,
   input  logic [KEY_BITS-1:0]      req_key,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [COUNT_BITS-1:0]    rsp_estimate,
   input  logic                     rsp_was_tracked,
   input  logic                     rsp_evicted,
   input  logic [KEY_BITS-1:0]      rsp_evicted_key,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COUNT_BITS-1:0] estimate;
      logic                  was_tracked;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } tally_type;

   logic [KEY_BITS-1:0]   mirror_key   [SLOTS];
   logic [COUNT_BITS-1:0] mirror_count [SLOTS];
   logic                  mirror_held  [SLOTS];
   int                    mirror_filled;
   logic [CAP_BITS-1:0]   mirror_cap;
   tally_type             due_tallies [$];

   task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t ns ssht check: %s got %0h, predicted %0h", $realtime, field, got, want);
      failures++;
   endtask

   function automatic logic [COUNT_BITS-1:0] saturating_bump(logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + COUNT_BITS'(1);
   endfunction

   // Applies one request word to the mirror and returns the response it must produce.
   function automatic tally_type predict_tally(op_type op, logic [KEY_BITS-1:0] key);
      tally_type t;
      int hit;
      int victim;
      int free_idx;
      int limit;
      t = '0;
      hit = -1;
      victim = -1;
      free_idx = -1;
      limit = (mirror_cap == 0) ? 1 : ((mirror_cap > SLOTS) ? SLOTS : int'(mirror_cap));
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && mirror_held[i] && mirror_key[i] == key)
            hit = i;
         if (free_idx < 0 && !mirror_held[i])
            free_idx = i;
         // Strictly smaller keeps the lowest index among equal minimum counts.
         if (mirror_held[i] && (victim < 0 || mirror_count[i] < mirror_count[victim]))
            victim = i;
      end
      t.was_tracked = (hit >= 0);
      if (op == OP_QUERY) begin
         if (hit >= 0)
            t.estimate = mirror_count[hit];
      end else if (hit >= 0) begin
         mirror_count[hit] = saturating_bump(mirror_count[hit]);
         t.estimate = mirror_count[hit];
      end else if (mirror_filled < limit) begin
         mirror_held[free_idx] = 1'b1;
         mirror_key[free_idx] = key;
         mirror_count[free_idx] = 1;
         mirror_filled++;
         t.estimate = 1;
      end else begin
         t.evicted = 1'b1;
         t.evicted_key = mirror_key[victim];
         mirror_count[victim] = saturating_bump(mirror_count[victim]);
         mirror_key[victim] = key;
         t.estimate = mirror_count[victim];
      end
      return t;
   endfunction

   always @(posedge clock) begin : watch
      tally_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            mirror_held[i] = 1'b0;
            mirror_count[i] = '0;
         end
         mirror_filled = 0;
         mirror_cap = ACTIVE_SLOTS_RESET;
         due_tallies.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_ACTIVE_SLOTS)
            mirror_cap = csr_pwdata[CAP_BITS-1:0];
         if (rsp_valid && rsp_ready) begin
            if (due_tallies.size() == 0) begin
               note_mismatch("response word with nothing outstanding",
                             64'(rsp_estimate), '0);
            end else begin
               want = due_tallies.pop_front();
               if (rsp_estimate !== want.estimate)
                  note_mismatch("estimate", 64'(rsp_estimate), 64'(want.estimate));
               if (rsp_was_tracked !== want.was_tracked)
                  note_mismatch("was_tracked", 64'(rsp_was_tracked),
                                64'(want.was_tracked));
               if (rsp_evicted !== want.evicted)
                  note_mismatch("evicted", 64'(rsp_evicted), 64'(want.evicted));
               // The replaced key reads as zero when nothing was evicted.
               if (rsp_evicted_key !== want.evicted_key)
                  note_mismatch("evicted_key", 64'(rsp_evicted_key),
                                64'(want.evicted_key));
            end
         end
         if (req_valid && req_ready)
            due_tallies.insert(due_tallies.size(), predict_tally(op_type'(req_op), req_key));
      end
      pending <= due_tallies.size();
   end

endmodule

// ----- verif/space_saving_heavy_hitter_table_unit_test.sv -----
// Top of the testbench for the space-saving frequent-key table unit: makes clock, reset,
// request words, capacity writes and response back-pressure, and gives the verdict.
// Depends on ssht_pkg, the unit itself and ssht_result_checker.
module space_saving_heavy_hitter_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ssht_pkg::*;

   localparam int PERIOD       = 8;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_GAP      = 18;
   // Long receiver hold-off, longer than the walk through the cell row.
   localparam int HOLD_CYCLES  = 400;
   // Quiet time after the last response, longer than the request-to-response path.
   localparam int DRAIN_CYCLES = 80;
   // The watchdog allows more than the slowest correct run of about 950 words.
   localparam int LIMIT_CYCLES = 600_000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 92;
   localparam int POOL_MAX     = 160;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_op = OP_UPDATE;
   logic [KEY_BITS-1:0]      req_key = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]    rsp_estimate;
   logic                     rsp_was_tracked;
   logic                     rsp_evicted;
   logic [KEY_BITS-1:0]      rsp_evicted_key;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       failures;
   int                       pending;

   // Per-phase idling switches, and a one-shot request for the long hold-off.
   bit                       sender_idles = 1'b1;
   bit                       receiver_idles = 1'b1;
   bit                       hold_now = 1'b0;

   // Keys of the current phase. Most request words draw from here so that keys
   // come back, get counted up and compete for the minimum slot.
   logic [KEY_BITS-1:0]      key_pool [POOL_MAX];
   int                       pool_len;

   always #(PERIOD / 2) clock = ~clock;

   space_saving_heavy_hitter_table_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .rsp_was_tracked (rsp_was_tracked),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // The checker sits beside the unit and only watches its ports.
   ssht_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .rsp_was_tracked (rsp_was_tracked),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .failures        (failures),
      .pending         (pending)
   );

   // Offers one request word and returns at the edge where it is taken. Valid is
   // only dropped when a gap is drawn, so back-to-back words keep it high.
   task automatic send_word(op_type op, logic [KEY_BITS-1:0] key);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering words and waits until every predicted response has come back.
   // The first edge lets the checker count the word accepted at this step.
   task automatic settle_table();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Writes the capacity register with a setup and an access phase. The upper data
   // bits are random; only the low bits of the register take effect.
   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      logic [CSR_DATA_BITS-1:0] upper;
      upper = $urandom;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_ACTIVE_SLOTS, 2'b00};
      csr_pwdata  <= {upper[CSR_DATA_BITS-1:CAP_BITS], cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Response side. While the receiver idles, each response word gets its own random
   // stall before ready is raised; when asked, one stall becomes a long hold-off so
   // that the unit backs up and drops req_ready while the sender keeps offering.
   initial begin : take_responses
      int gap;
      forever begin
         if (hold_now) begin
            gap = HOLD_CYCLES;
            hold_now = 1'b0;
         end else begin
            gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * PERIOD);
      $display("FAIL space_saving_heavy_hitter_table_unit");
      $finish;
   end

   initial begin : stimulus
      int                  eff;
      int                  a;
      int                  b;
      int                  pick;
      logic [CAP_BITS-1:0] cap;
      logic [KEY_BITS-1:0] key;
      op_type              op;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A capacity of two makes the table full after two keys, so
      // the first few words already reach hits, fills, untracked queries and the
      // choice between equal minimum counts.
      write_capacity(7'd2);
      send_word(OP_UPDATE, 32'h0000_0000);
      send_word(OP_UPDATE, 32'h0000_0000);
      send_word(OP_UPDATE, 32'hFFFF_FFFF);
      send_word(OP_QUERY,  32'h0000_0000);
      send_word(OP_QUERY,  32'h1234_5678);
      send_word(OP_UPDATE, 32'h8000_0000);
      send_word(OP_UPDATE, 32'h7FFF_FFFF);
      send_word(OP_QUERY,  32'h0000_0000);
      send_word(OP_QUERY,  32'h7FFF_FFFF);
      settle_table();

      // A capacity of zero acts as one, and it is now below the filled count:
      // entries stay tracked and each updated new key evicts the minimum-count entry.
      write_capacity(7'd0);
      send_word(OP_UPDATE, 32'h0000_0001);
      send_word(OP_UPDATE, 32'h0000_FFFF);
      send_word(OP_QUERY,  32'hFFFF_0000);
      settle_table();

      // The largest register value acts as the full slot count, so new keys fill.
      write_capacity(7'd127);
      send_word(OP_UPDATE, 32'hFFFF_0000);
      send_word(OP_UPDATE, 32'hFFFF_FFFF);
      settle_table();

      // Random phases, each with its own capacity, key pool and idling pattern.
      // The capacities walk through the extremes and drop below the filled count
      // after the table has filled up.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       cap = 7'd64;
            1:       cap = 7'd1;
            2:       cap = 7'd65;
            3:       cap = 7'd5;
            4:       cap = 7'd127;
            5:       cap = 7'd3;
            6:       cap = 7'd0;
            7:       cap = CAP_BITS'($urandom_range(0, 127));
            8:       cap = 7'd40;
            default: cap = 7'd2;
         endcase
         write_capacity(cap);

         // The pool runs from about the capacity to a little over twice it, so
         // some phases mostly hit and others keep evicting.
         eff = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : int'(cap));
         pool_len = eff + $urandom_range(0, eff + 8);
         for (int i = 0; i < pool_len; i++)
            key_pool[i] = $urandom;

         // Idling pattern: both sides, neither, sender only, receiver only.
         sender_idles   = (ph % 4 == 0) || (ph % 4 == 2);
         receiver_idles = (ph % 4 == 0) || (ph % 4 == 3);
         if (ph == 2)
            hold_now = 1'b1;

         for (int n = 0; n < PHASE_WORDS; n++) begin
            op = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_UPDATE;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // The smaller of two draws favors the front of the pool, which
               // gives a few heavy keys and a long tail of light ones.
               a = $urandom_range(0, pool_len - 1);
               b = $urandom_range(0, pool_len - 1);
               key = key_pool[(a < b) ? a : b];
            end else if (pick < 90) begin
               key = $urandom;
            end else begin
               // A pool key with one bit flipped: a near miss for the key compare.
               key = key_pool[$urandom_range(0, pool_len - 1)] ^
                     (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
            end
            send_word(op, key);
         end
         settle_table();
      end

      // Everything has come back; give a stray response word time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS space_saving_heavy_hitter_table_unit");
      else
         $display("FAIL space_saving_heavy_hitter_table_unit");
      $finish;
   end

endmodule
